@@ rtl/sle_pkg.sv @@
// Shared types and constants for the serial line editor.
// No dependencies; every other file in rtl/ imports this package.
package sle_pkg;

    // Line store and count widths
    localparam int STORE_DEPTH = 1024;
    localparam int LEN_W       = 10;
    localparam int CHAR_W      = 8;
    localparam logic [LEN_W-1:0] LEN_MAX   = '1;
    localparam logic [LEN_W-1:0] LIMIT_CAP =
        (STORE_DEPTH - 1 > 1023) ? LEN_MAX : LEN_W'(STORE_DEPTH - 1);

    // Command queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // Output beat packing
    localparam int OUT_W  = 39;
    localparam int TDATA_W = ((OUT_W + 7) / 8) * 8;

    // Configuration register indexes
    localparam logic CFG_ECHO_PLAIN = 1'b0;
    localparam logic CFG_MAX_LENGTH = 1'b1;

    // Received byte codes
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CHAR_ESC   = 8'd27;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;
    localparam logic [CHAR_W-1:0] CHAR_STAR  = 8'd42;
    localparam logic [CHAR_W-1:0] CHAR_TILDE = 8'd126;
    localparam logic [CHAR_W-1:0] CHAR_DEL   = 8'd127;
    localparam logic [CHAR_W-1:0] CHAR_LBR   = 8'd91;
    localparam logic [CHAR_W-1:0] CHAR_ONE   = 8'd49;
    localparam logic [CHAR_W-1:0] CHAR_D     = 8'd68;
    localparam logic [CHAR_W-1:0] CHAR_K     = 8'd75;

    // Command kinds
    typedef logic [1:0] t_kind;
    localparam t_kind K_ERASE = 2'd0;
    localparam t_kind K_CR    = 2'd1;
    localparam t_kind K_LF    = 2'd2;
    localparam t_kind K_PRINT = 2'd3;

    // Steps inside one command
    typedef logic [2:0] t_step;
    localparam t_step ERASE_LAST = 3'd6;

    // One classified input, everything the back end needs
    typedef struct packed {
        t_kind             kind;
        logic              wrap;    // printable byte that hit the limit
        logic [CHAR_W-1:0] echo;    // echo byte for a printable
        logic [CHAR_W-1:0] chr;     // byte to store for a printable
        logic [LEN_W-1:0]  index;   // store position of a printable
        logic [LEN_W-1:0]  term;    // store position of the terminator
        logic [LEN_W-1:0]  length;  // count after this input
    } t_cmd;

    // One result beat
    typedef struct packed {
        logic              tx_valid;
        logic [CHAR_W-1:0] tx_char;
        logic              store_valid;
        logic [LEN_W-1:0]  store_index;
        logic [CHAR_W-1:0] store_char;
        logic              line_done;
        logic [LEN_W-1:0]  line_length;
        logic              last;
    } t_res;

    // Cursor-back and erase-to-end sequence
    function automatic logic [CHAR_W-1:0] erase_char(input t_step s);
        logic [CHAR_W-1:0] c;
        case (s)
            3'd0, 3'd4: c = CHAR_ESC;
            3'd1, 3'd5: c = CHAR_LBR;
            3'd2:       c = CHAR_ONE;
            3'd3:       c = CHAR_D;
            3'd6:       c = CHAR_K;
            default:    c = '0;
        endcase
        return c;
    endfunction

endpackage

@@ rtl/sle_front.sv @@
// Front end: holds configuration and the character count, classifies each
// received byte and pushes one command per non-ignored byte. Uses sle_pkg.
module sle_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [sle_pkg::LEN_W-1:0]   i_cfg_data,
    input  logic                        i_valid,
    input  logic [sle_pkg::CHAR_W-1:0]  i_char,
    input  logic                        i_q_full,
    output logic                        o_ready,
    output logic                        o_push,
    output sle_pkg::t_cmd               o_cmd
);
    import sle_pkg::*;

    logic             r_echo_plain;
    logic [LEN_W-1:0] r_max_length;
    logic [LEN_W-1:0] r_count, n_count;
    logic [LEN_W-1:0] limit;
    logic [LEN_W-1:0] count_inc;
    logic             keep;
    logic             accept;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_echo_plain <= 1'b1;
            r_max_length <= 10'd1022;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_ECHO_PLAIN) begin
                r_echo_plain <= i_cfg_data[0];
            end else begin
                r_max_length <= i_cfg_data;
            end
        end
    end

    // Effective limit: clamp to store size, zero acts as one
    always_comb begin
        limit = (r_max_length > LIMIT_CAP) ? LIMIT_CAP : r_max_length;
        if (limit == '0) begin
            limit = LEN_W'(1);
        end
    end

    assign count_inc = r_count + LEN_W'(1);
    assign o_ready   = !i_q_full;
    assign accept    = i_valid && o_ready;

    // Classify the byte and work out the count effect
    always_comb begin
        keep         = 1'b0;
        n_count      = r_count;
        o_cmd        = '0;
        o_cmd.chr    = i_char;
        o_cmd.echo   = r_echo_plain ? i_char : CHAR_STAR;
        o_cmd.index  = r_count;
        o_cmd.term   = r_count;
        if (i_char == CHAR_DEL) begin
            keep       = (r_count != '0);
            o_cmd.kind = K_ERASE;
            n_count    = r_count - LEN_W'(1);
        end else if (i_char == CHAR_CR) begin
            keep       = 1'b1;
            o_cmd.kind = K_CR;
            n_count    = '0;
        end else if (i_char == CHAR_LF) begin
            keep       = 1'b1;
            o_cmd.kind = K_LF;
            n_count    = '0;
        end else if (i_char >= CHAR_SPACE && i_char <= CHAR_TILDE) begin
            keep       = 1'b1;
            o_cmd.kind = K_PRINT;
            o_cmd.term = count_inc;
            o_cmd.wrap = (count_inc >= limit);
            n_count    = o_cmd.wrap ? '0 : count_inc;
        end
        o_cmd.length = n_count;
    end

    assign o_push = accept && keep;

    // Advance the count on each kept byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (o_push) begin
            r_count <= n_count;
        end
    end

endmodule

@@ rtl/sle_cmdq.sv @@
// Short command queue between front and back end.
// Register-based FIFO of t_cmd entries; uses sle_pkg.
module sle_cmdq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sle_pkg::t_cmd  i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output sle_pkg::t_cmd  o_cmd
);
    import sle_pkg::*;

    t_cmd            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr, r_rd;
    logic [Q_AW:0]   r_cnt;

    assign o_full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + Q_AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + Q_AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + (Q_AW+1)'(1);
                2'b01:   r_cnt <= r_cnt - (Q_AW+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push || i_pop)
        else $error("command pushed into full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("command popped from empty queue");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (Q_AW+1)'(Q_DEPTH))
        else $error("queue fill count out of range");
`endif

endmodule

@@ rtl/sle_back.sv @@
// Back end: sequences the result beats of each command into an output
// register, one beat per cycle unless the output stalls. Uses sle_pkg.
module sle_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  sle_pkg::t_cmd  i_q_cmd,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output sle_pkg::t_res  o_res
);
    import sle_pkg::*;

    logic  r_busy;
    t_cmd  r_cmd;
    t_step r_step;
    logic  r_out_valid;
    t_res  r_out;

    t_cmd  cur;
    t_res  res;
    logic  have;
    logic  advance;
    logic  tail;
    t_step ph;

    assign cur     = r_busy ? r_cmd : i_q_cmd;
    assign have    = r_busy || i_q_valid;
    assign advance = !r_out_valid || i_ready;
    assign o_pop   = advance && have && !r_busy;

    // Build the beat for the current command and step
    always_comb begin
        res             = '0;
        res.line_length = cur.length;
        tail            = 1'b0;
        ph              = r_step;
        case (cur.kind)
            K_ERASE: begin
                res.tx_valid = 1'b1;
                res.tx_char  = erase_char(r_step);
                res.last     = (r_step == ERASE_LAST);
            end
            K_CR: begin
                tail = 1'b1;
            end
            K_LF: begin
                res.store_valid = 1'b1;
                res.store_index = cur.term;
                res.line_done   = 1'b1;
                res.last        = 1'b1;
            end
            default: begin
                if (r_step == '0) begin
                    res.tx_valid    = 1'b1;
                    res.tx_char     = cur.echo;
                    res.store_valid = 1'b1;
                    res.store_index = cur.index;
                    res.store_char  = cur.chr;
                    res.last        = !cur.wrap;
                end else begin
                    tail = 1'b1;
                    ph   = r_step - t_step'(1);
                end
            end
        endcase
        // CR LF line end with terminator write on the LF beat
        if (tail) begin
            res.tx_valid = 1'b1;
            if (ph == '0) begin
                res.tx_char = CHAR_CR;
            end else begin
                res.tx_char     = CHAR_LF;
                res.store_valid = 1'b1;
                res.store_index = cur.term;
                res.line_done   = 1'b1;
                res.last        = 1'b1;
            end
        end
    end

    // Step through the command, load from queue head on its first beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= have;
            if (have) begin
                if (res.last) begin
                    r_busy <= 1'b0;
                    r_step <= '0;
                end else begin
                    r_busy <= 1'b1;
                    r_step <= r_step + t_step'(1);
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (advance && have) begin
            r_out <= res;
        end
        if (o_pop) begin
            r_cmd <= i_q_cmd;
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;

`ifndef NO_ASSERTIONS
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_step != '0 && r_step <= ERASE_LAST)
        else $error("sequencer step out of range");
    a_done_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.line_done |-> r_out.line_length == '0 && r_out.last)
        else $error("line end beat with nonzero length");
    a_idle_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.store_valid |->
            r_out.store_index == '0 && r_out.store_char == '0)
        else $error("store fields set without a store write");
    a_idle_tx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.tx_valid |-> r_out.tx_char == '0)
        else $error("echo byte set without tx_valid");
`endif

endmodule

@@ rtl/serial_line_editor_core.sv @@
// Serial line editor top level: front end, command queue and back end.
// Depends on sle_pkg, sle_front, sle_cmdq and sle_back.
//
//  channel   dir  beat contents
//  s_axis    in   tdata[7:0] rx_char
//  m_axis    out  tdata: result fields (see port), tlast: last result of input
//  cfg       in   we / idx / data: 0 echo_plain, 1 max_length
//
// A received byte is classified combinationally and queued; ignored bytes
// are dropped there. The back end emits one result beat per cycle unless
// m_axis stalls: 1 for a printable or LF, 2 for CR, 3 for a printable that
// ends the line, 7 for an erase; beats per command set the sustained rate.
// Synchronous active-low reset clears count, queue and sequencer; config
// returns to echo_plain = 1, max_length = 1022. Output stalls back up into
// the four-entry queue before s_axis tready drops.
module serial_line_editor_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [sle_pkg::LEN_W-1:0]     i_cfg_data,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [7:0]                    i_s_axis_tdata,   // [7:0] rx_char
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // [0] tx_valid, [8:1] tx_char, [9] store_valid, [19:10] store_index,
    // [27:20] store_char, [28] line_done, [38:29] line_length, [39] zero
    output logic [sle_pkg::TDATA_W-1:0]   o_m_axis_tdata,
    output logic                          o_m_axis_tlast
);
    import sle_pkg::*;

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_valid;
    t_cmd push_cmd;
    t_cmd head_cmd;
    t_res out_res;

    sle_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_s_axis_tvalid),
        .i_char     (i_s_axis_tdata),
        .i_q_full   (q_full),
        .o_ready    (o_s_axis_tready),
        .o_push     (q_push),
        .o_cmd      (push_cmd)
    );

    sle_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    sle_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (head_cmd),
        .o_pop     (q_pop),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_res     (out_res)
    );

    // Pack the result beat, first field lowest
    assign o_m_axis_tdata = {1'b0, out_res.line_length, out_res.line_done,
                             out_res.store_char, out_res.store_index,
                             out_res.store_valid, out_res.tx_char,
                             out_res.tx_valid};
    assign o_m_axis_tlast = out_res.last;

endmodule
